/* hw/rtl/bcf_pkg.sv */
package bcf_pkg;

  // Accumulator width of the forward-difference registers (wraps mod 2^64)
  localparam int ACC_W = 64;
  // Output coordinate width, point index width, point count width
  localparam int OUT_W = 17;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // One prepared curve: skewed difference registers, start point and count
  typedef struct packed {
    logic [ACC_W-1:0] pos_x;
    logic [ACC_W-1:0] vel_x;
    logic [ACC_W-1:0] acc_x;
    logic [ACC_W-1:0] jerk_x;
    logic [ACC_W-1:0] pos_y;
    logic [ACC_W-1:0] vel_y;
    logic [ACC_W-1:0] acc_y;
    logic [ACC_W-1:0] jerk_y;
    logic [OUT_W-1:0] p0_x;
    logic [OUT_W-1:0] p0_y;
    logic [CNT_W-1:0] count;
  } setup_t;

endpackage

/* hw/rtl/bcf_if.sv */
// Request channel: four control points and a point count
interface bcf_req_if #(
  parameter int COORD_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  p0_x;
  logic signed [COORD_BITS-1:0]  p0_y;
  logic signed [COORD_BITS-1:0]  p1_x;
  logic signed [COORD_BITS-1:0]  p1_y;
  logic signed [COORD_BITS-1:0]  p2_x;
  logic signed [COORD_BITS-1:0]  p2_y;
  logic signed [COORD_BITS-1:0]  p3_x;
  logic signed [COORD_BITS-1:0]  p3_y;
  logic [bcf_pkg::CNT_W-1:0]     point_count;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, point_count,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, point_count,
    output ready
  );
endinterface

// Point channel: one curve point per transaction
interface bcf_pt_if;
  logic                           valid;
  logic                           ready;
  logic signed [bcf_pkg::OUT_W-1:0] out_x;
  logic signed [bcf_pkg::OUT_W-1:0] out_y;
  logic [bcf_pkg::IDX_W-1:0]      point_index;
  logic                           last_point;

  modport source (
    output valid, out_x, out_y, point_index, last_point,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, point_index, last_point,
    output ready
  );
endinterface

/* hw/rtl/bcf_front.sv */
module bcf_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 32,
  parameter int MAX_PTS    = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bcf_req_if.sink          req_i,
  input  bcf_pkg::qstat_t  qstat_i,
  output logic             push_o,
  output bcf_pkg::setup_t  entry_o
);
  import bcf_pkg::*;

  localparam int A_W   = COORD_BITS + 4;          // polynomial coefficient width
  localparam int DT_W  = FRAC_BITS + 1;           // dt can reach 1.0
  localparam int CH_W  = 16;                      // dt slice per multiply cycle
  localparam int NCH   = (DT_W + CH_W - 1) / CH_W;
  localparam int DTP_W = NCH * CH_W;
  localparam int CHI_W = $clog2(NCH);
  localparam int P_W   = A_W + CH_W + 1;
  localparam int TI_W  = $clog2(MAX_PTS);

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_LOOK = 7'b0000010,
    F_MUL  = 7'b0000100,
    F_C1   = 7'b0001000,
    F_C2   = 7'b0010000,
    F_C3   = 7'b0100000,
    F_PUSH = 7'b1000000
  } fstate_e;

  typedef enum logic [2:0] {
    OP_A2X = 3'd0,
    OP_A3X = 3'd1,
    OP_B1X = 3'd2,
    OP_A2Y = 3'd3,
    OP_A3Y = 3'd4,
    OP_B1Y = 3'd5
  } mul_op_e;

  // Tables of 1/n, 1/n^2, 1/n^3 (n the step count), rounded half up, elaborated
  logic [DT_W-1:0] dt1_tbl [MAX_PTS];
  logic [DT_W-1:0] dt2_tbl [MAX_PTS];
  logic [DT_W-1:0] dt3_tbl [MAX_PTS];

  for (genvar g = 0; g < MAX_PTS; g++) begin : g_tbl
    localparam logic [ACC_W-1:0] DV  = (g == 0) ? 64'd1 : 64'(g);
    localparam logic [ACC_W-1:0] DV2 = DV * DV;
    localparam logic [ACC_W-1:0] DV3 = DV2 * DV;
    localparam logic [ACC_W-1:0] ONE = 64'd1 << FRAC_BITS;
    localparam logic [ACC_W-1:0] DT1 = (ONE + DV / 64'd2) / DV;
    localparam logic [ACC_W-1:0] DT2 = (ONE + DV2 / 64'd2) / DV2;
    localparam logic [ACC_W-1:0] DT3 = (ONE + DV3 / 64'd2) / DV3;
    assign dt1_tbl[g] = DT1[DT_W-1:0];
    assign dt2_tbl[g] = DT2[DT_W-1:0];
    assign dt3_tbl[g] = DT3[DT_W-1:0];
  end

  function automatic logic signed [A_W-1:0] coef_a2(
    input logic signed [A_W-1:0] c0,
    input logic signed [A_W-1:0] c1,
    input logic signed [A_W-1:0] c2
  );
    logic signed [A_W-1:0] s;
    s = c2 - (c1 <<< 1) + c0;
    return (s <<< 1) + s;
  endfunction

  function automatic logic signed [A_W-1:0] coef_a3(
    input logic signed [A_W-1:0] c0,
    input logic signed [A_W-1:0] c1,
    input logic signed [A_W-1:0] c2,
    input logic signed [A_W-1:0] c3
  );
    return c3 - ((c2 <<< 1) + c2) + ((c1 <<< 1) + c1) - c0;
  endfunction

  function automatic logic signed [A_W-1:0] coef_b1(
    input logic signed [A_W-1:0] c0,
    input logic signed [A_W-1:0] c1
  );
    logic signed [A_W-1:0] s;
    s = c1 - c0;
    return (s <<< 1) + s;
  endfunction

  fstate_e            state_q, state_d;
  mul_op_e            op_q, op_d, op_next;
  logic [CHI_W-1:0]   chunk_q, chunk_d;
  logic               in_ready;
  logic               accept;
  logic               last_chunk;

  logic [CNT_W-1:0]   n_sat;
  logic [CNT_W-1:0]   n_q;
  logic [TI_W-1:0]    tidx;

  logic signed [A_W-1:0] c0x, c1x, c2x, c3x, c0y, c1y, c2y, c3y;
  logic signed [COORD_BITS-1:0] c0x_q, c0y_q;
  logic signed [A_W-1:0] a2x_q, a3x_q, b1x_q, a2y_q, a3y_q, b1y_q;
  logic [DT_W-1:0]    dt1_q, dt2_q, dt3_q;

  logic signed [A_W-1:0] a_sel;
  logic [DT_W-1:0]    dt_sel;
  logic [DTP_W-1:0]   dt_pad;
  logic [CH_W-1:0]    chunk;
  logic signed [P_W-1:0] prod;
  logic [ACC_W-1:0]   pp, mac_q, mac_d;

  logic [ACC_W-1:0]   t2x_q, t3x_q, t1x_q, t2y_q, t3y_q, t1y_q;
  logic [ACC_W-1:0]   six_x, six_y;
  logic [ACC_W-1:0]   jx_q, ax_q, vx_q, jy_q, ay_q, vy_q;
  logic signed [ACC_W-1:0] c0x64, c0y64;
  logic [ACC_W-1:0]   half;

  // Handshake and count saturation
  assign in_ready    = (state_q == F_IDLE);
  assign req_i.ready = in_ready;
  assign accept      = req_i.valid && in_ready;
  assign n_sat       = (int'(req_i.point_count) > MAX_PTS) ? CNT_W'(MAX_PTS)
                                                           : req_i.point_count;
  assign tidx        = TI_W'(n_q - CNT_W'(1));

  // Sign-extended control points
  assign c0x = A_W'(req_i.p0_x);
  assign c1x = A_W'(req_i.p1_x);
  assign c2x = A_W'(req_i.p2_x);
  assign c3x = A_W'(req_i.p3_x);
  assign c0y = A_W'(req_i.p0_y);
  assign c1y = A_W'(req_i.p1_y);
  assign c2y = A_W'(req_i.p2_y);
  assign c3y = A_W'(req_i.p3_y);

  // Shared multiplier: coefficient times one dt slice per cycle
  always_comb begin
    unique case (op_q)
      OP_A2X: begin a_sel = a2x_q; dt_sel = dt2_q; op_next = OP_A3X; end
      OP_A3X: begin a_sel = a3x_q; dt_sel = dt3_q; op_next = OP_B1X; end
      OP_B1X: begin a_sel = b1x_q; dt_sel = dt1_q; op_next = OP_A2Y; end
      OP_A2Y: begin a_sel = a2y_q; dt_sel = dt2_q; op_next = OP_A3Y; end
      OP_A3Y: begin a_sel = a3y_q; dt_sel = dt3_q; op_next = OP_B1Y; end
      OP_B1Y: begin a_sel = b1y_q; dt_sel = dt1_q; op_next = OP_A2X; end
      default: begin a_sel = a2x_q; dt_sel = dt2_q; op_next = OP_A2X; end
    endcase
  end

  assign dt_pad     = DTP_W'(dt_sel);
  assign chunk      = dt_pad[chunk_q*CH_W +: CH_W];
  assign prod       = a_sel * $signed({1'b0, chunk});
  assign pp         = {{(ACC_W-P_W){prod[P_W-1]}}, prod} << (chunk_q * CH_W);
  assign mac_d      = ((chunk_q == '0) ? '0 : mac_q) + pp;
  assign last_chunk = (chunk_q == CHI_W'(NCH - 1));

  // Sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    chunk_d = chunk_q;
    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid) state_d = (n_sat < CNT_W'(2)) ? F_PUSH : F_LOOK;
      end
      F_LOOK: begin
        state_d = F_MUL;
        op_d    = OP_A2X;
        chunk_d = '0;
      end
      F_MUL: begin
        if (last_chunk) begin
          chunk_d = '0;
          if (op_q == OP_B1Y) state_d = F_C1;
          else op_d = op_next;
        end else begin
          chunk_d = chunk_q + CHI_W'(1);
        end
      end
      F_C1: state_d = F_C2;
      F_C2: state_d = F_C3;
      F_C3: state_d = F_PUSH;
      F_PUSH: begin
        if (!qstat_i.full) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      op_q    <= OP_A2X;
      chunk_q <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      chunk_q <= chunk_d;
    end
  end

  // Six times the cubic term feeds both jerk and acceleration
  assign six_x = (t3x_q << 2) + (t3x_q << 1);
  assign six_y = (t3y_q << 2) + (t3y_q << 1);

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q   <= n_sat;
      c0x_q <= req_i.p0_x;
      c0y_q <= req_i.p0_y;
      a2x_q <= coef_a2(c0x, c1x, c2x);
      a3x_q <= coef_a3(c0x, c1x, c2x, c3x);
      b1x_q <= coef_b1(c0x, c1x);
      a2y_q <= coef_a2(c0y, c1y, c2y);
      a3y_q <= coef_a3(c0y, c1y, c2y, c3y);
      b1y_q <= coef_b1(c0y, c1y);
    end
    if (state_q == F_LOOK) begin
      dt1_q <= dt1_tbl[tidx];
      dt2_q <= dt2_tbl[tidx];
      dt3_q <= dt3_tbl[tidx];
    end
    if (state_q == F_MUL) begin
      mac_q <= mac_d;
      if (last_chunk) begin
        unique case (op_q)
          OP_A2X: t2x_q <= mac_d;
          OP_A3X: t3x_q <= mac_d;
          OP_B1X: t1x_q <= mac_d;
          OP_A2Y: t2y_q <= mac_d;
          OP_A3Y: t3y_q <= mac_d;
          OP_B1Y: t1y_q <= mac_d;
          default: ;
        endcase
      end
    end
    // Initial differences
    if (state_q == F_C1) begin
      jx_q <= six_x;
      ax_q <= (t2x_q << 1) - six_x;
      vx_q <= t3x_q - t2x_q + t1x_q;
      jy_q <= six_y;
      ay_q <= (t2y_q << 1) - six_y;
      vy_q <= t3y_q - t2y_q + t1y_q;
    end
    // Skew: acceleration two steps ahead, velocity one step ahead
    if (state_q == F_C2) begin
      ax_q <= ax_q + jx_q;
      ay_q <= ay_q + jy_q;
    end
    if (state_q == F_C3) begin
      vx_q <= vx_q + ax_q;
      ax_q <= ax_q + jx_q;
      vy_q <= vy_q + ay_q;
      ay_q <= ay_q + jy_q;
    end
  end

  // Queue entry
  assign c0x64 = ACC_W'(c0x_q);
  assign c0y64 = ACC_W'(c0y_q);
  assign half  = 64'd1 << (FRAC_BITS - 1);

  assign push_o         = (state_q == F_PUSH) && !qstat_i.full;
  assign entry_o.pos_x  = (c0x64 << FRAC_BITS) + half;
  assign entry_o.vel_x  = vx_q;
  assign entry_o.acc_x  = ax_q;
  assign entry_o.jerk_x = jx_q;
  assign entry_o.pos_y  = (c0y64 << FRAC_BITS) + half;
  assign entry_o.vel_y  = vy_q;
  assign entry_o.acc_y  = ay_q;
  assign entry_o.jerk_y = jy_q;
  assign entry_o.p0_x   = c0x64[OUT_W-1:0];
  assign entry_o.p0_y   = c0y64[OUT_W-1:0];
  assign entry_o.count  = n_q;

endmodule

/* hw/rtl/bcf_queue.sv */
module bcf_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bcf_pkg::setup_t  entry_i,
  input  logic             pop_i,
  output bcf_pkg::setup_t  entry_o,
  output bcf_pkg::qstat_t  qstat_o
);
  import bcf_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  setup_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [FILL_W-1:0] fill_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign entry_o       = mem_q[rd_q];
  assign qstat_o.full  = (fill_q == FILL_W'(DEPTH));
  assign qstat_o.empty = (fill_q == '0);

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      unique case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + FILL_W'(1);
        2'b01:   fill_q <= fill_q - FILL_W'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

/* hw/rtl/bcf_back.sv */
module bcf_back #(
  parameter int FRAC_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bcf_pkg::qstat_t  qstat_i,
  input  bcf_pkg::setup_t  entry_i,
  output logic             pop_o,
  bcf_pt_if.source         pt_o
);
  import bcf_pkg::*;

  // Truncate toward zero: floor, then bump negatives with a nonzero fraction
  function automatic logic [OUT_W-1:0] trunc_pt(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] sh;
    logic             rnd;
    sh  = $signed(v) >>> FRAC_BITS;
    rnd = v[ACC_W-1] & (|v[FRAC_BITS-1:0]);
    return sh[OUT_W-1:0] + {{(OUT_W-1){1'b0}}, rnd};
  endfunction

  logic              busy_q;
  logic              ov_q;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  last_idx_q;
  logic              out_free;
  logic              step;
  logic              is_last;
  logic              single;

  logic [ACC_W-1:0]  px_q, vx_q, ax_q, jx_q, py_q, vy_q, ay_q, jy_q;
  logic [ACC_W-1:0]  sum_x, sum_y;
  logic [OUT_W-1:0]  ox_q, oy_q;
  logic [IDX_W-1:0]  oidx_q;
  logic              olast_q;

  assign out_free = !ov_q || pt_o.ready;
  assign pop_o    = !busy_q && !qstat_i.empty && out_free;
  assign step     = busy_q && out_free;
  assign idx_d    = idx_q + CNT_W'(1);
  assign is_last  = (idx_d == last_idx_q);
  assign single   = (entry_i.count < CNT_W'(2));
  assign sum_x    = px_q + vx_q;
  assign sum_y    = py_q + vy_q;

  // Run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      idx_q  <= '0;
    end else begin
      priority if (pop_o) begin
        busy_q <= !single;
        ov_q   <= 1'b1;
        idx_q  <= '0;
      end else if (step) begin
        busy_q <= !is_last;
        ov_q   <= 1'b1;
        idx_q  <= idx_d;
      end else if (pt_o.ready) begin
        ov_q   <= 1'b0;
      end
    end
  end

  // Difference registers and output register
  always_ff @(posedge clk_i) begin
    priority if (pop_o) begin
      px_q       <= entry_i.pos_x;
      vx_q       <= entry_i.vel_x;
      ax_q       <= entry_i.acc_x;
      jx_q       <= entry_i.jerk_x;
      py_q       <= entry_i.pos_y;
      vy_q       <= entry_i.vel_y;
      ay_q       <= entry_i.acc_y;
      jy_q       <= entry_i.jerk_y;
      last_idx_q <= entry_i.count - CNT_W'(1);
      ox_q       <= entry_i.p0_x;
      oy_q       <= entry_i.p0_y;
      oidx_q     <= '0;
      olast_q    <= single;
    end else if (step) begin
      px_q    <= sum_x;
      vx_q    <= vx_q + ax_q;
      ax_q    <= ax_q + jx_q;
      py_q    <= sum_y;
      vy_q    <= vy_q + ay_q;
      ay_q    <= ay_q + jy_q;
      ox_q    <= trunc_pt(sum_x);
      oy_q    <= trunc_pt(sum_y);
      oidx_q  <= idx_d[IDX_W-1:0];
      olast_q <= is_last;
    end else begin
      ox_q <= ox_q;
    end
  end

  assign pt_o.valid       = ov_q;
  assign pt_o.out_x       = ox_q;
  assign pt_o.out_y       = oy_q;
  assign pt_o.point_index = oidx_q;
  assign pt_o.last_point  = olast_q;

endmodule

/* hw/rtl/cubic_bezier_forward_diff_core.sv */
// A count below two skips setup and goes straight to the push; otherwise the
// first point follows the table lookup, 6 x 3 sliced multiplies on the shared
// multiplier, the setup states F_C1 to F_C3, push and pop. Points leave one per
// cycle while the receiver is ready; the front sequencer and the point stepper
// overlap via a queue, so a new request is prepared while a curve streams.
// Reset: asynchronous active low, clears sequencer, queue and output valid.
module cubic_bezier_forward_diff_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 32,
  parameter int MAX_PTS    = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcf_req_if.sink   req_i,
  bcf_pt_if.source  pt_o
);
  import bcf_pkg::*;

  localparam int QDEPTH = 2;

  logic    q_push;
  logic    q_pop;
  setup_t  q_in;
  setup_t  q_out;
  qstat_t  q_stat;

  // Setup: reciprocals, coefficients and initial differences
  bcf_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_PTS    (MAX_PTS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .qstat_i (q_stat),
    .push_o  (q_push),
    .entry_o (q_in)
  );

  // Prepared curves waiting for the stepper
  bcf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .qstat_o (q_stat)
  );

  // Point stepper
  bcf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (q_stat),
    .entry_i (q_out),
    .pop_o   (q_pop),
    .pt_o    (pt_o)
  );

  // Queue never written when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_stat.full))
    else $error("setup queue overflow");

  // Queue never read when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_stat.empty))
    else $error("setup queue underflow");

  // Points of one curve stream without gaps once taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (pt_o.valid && pt_o.ready && !pt_o.last_point) |=> pt_o.valid)
    else $error("gap inside a curve");

endmodule

/* tb/tb_top.sv */
module tb_top;

  import bcf_pkg::*;

  localparam int COORD_W     = 16;
  localparam int FRAC_W      = 32;
  localparam int MAX_PTS     = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_CURVES = 96;
  localparam int DRAIN_LIMIT = 100000;
  localparam int TAIL_CYCLES = 64;

  typedef logic [ACC_W-1:0] fx_t;

  // One request: four control points and a point count
  typedef struct {
    logic signed [COORD_W-1:0] px [4];
    logic signed [COORD_W-1:0] py [4];
    logic [CNT_W-1:0]          count;
  } curve_t;

  // One emitted curve point
  typedef struct {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [IDX_W-1:0] idx;
    logic             last;
  } point_t;

  // Receiver stall patterns
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_EVERY_THIRD,
    RDY_MOSTLY
  } rdy_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  bcf_req_if #(.COORD_BITS(COORD_W)) req_if ();
  bcf_pt_if                          pt_if ();

  cubic_bezier_forward_diff_core #(
    .COORD_BITS (COORD_W),
    .FRAC_BITS  (FRAC_W),
    .MAX_PTS    (MAX_PTS)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .pt_o   (pt_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected points, oldest first
  point_t expected_pts [$];
  int     err_cnt;
  int     burst_left;
  logic   hold_req;

  // Forward-difference registers of the predictor
  fx_t x_pos, x_vel, x_acc, x_jerk;
  fx_t y_pos, y_vel, y_acc, y_jerk;

  function automatic fx_t widen_coord(logic signed [COORD_W-1:0] v);
    return {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // Truncate toward zero, keep the low output bits
  function automatic logic [OUT_W-1:0] trunc_to_point(fx_t v);
    fx_t q;
    if (v[ACC_W-1]) begin
      q = (-v) >> FRAC_W;
      q = -q;
    end else begin
      q = v >> FRAC_W;
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic void prepare_axis(input fx_t c0, c1, c2, c3, dt, dt2, dt3,
                                       output fx_t pos, vel, acc, jerk);
    fx_t a2, a3, t2, t3;
    a2   = 3 * (c2 - 2 * c1 + c0);
    a3   = c3 - 3 * c2 + 3 * c1 - c0;
    t2   = a2 * dt2;
    t3   = a3 * dt3;
    jerk = 6 * t3;
    acc  = 2 * t2 - 6 * t3;
    vel  = t3 - t2 + 3 * (c1 - c0) * dt;
    pos  = (c0 << FRAC_W) + (fx_t'(1) << (FRAC_W - 1));
  endfunction

  // Work out every point one request produces
  function automatic void predict_curve(curve_t c);
    fx_t    cx [4];
    fx_t    cy [4];
    fx_t    one, d, d2, d3, dt, dt2, dt3;
    int     n;
    point_t p;
    for (int k = 0; k < 4; k++) begin
      cx[k] = widen_coord(c.px[k]);
      cy[k] = widen_coord(c.py[k]);
    end
    n = (c.count > MAX_PTS) ? MAX_PTS : int'(c.count);
    // start point is P0 as given
    p.x    = cx[0][OUT_W-1:0];
    p.y    = cy[0][OUT_W-1:0];
    p.idx  = '0;
    p.last = (n < 2);
    expected_pts.push_back(p);
    if (n < 2) return;
    one = fx_t'(1) << FRAC_W;
    d   = fx_t'(n - 1);
    d2  = d * d;
    d3  = d2 * d;
    dt  = (one + d / 2) / d;
    dt2 = (one + d2 / 2) / d2;
    dt3 = (one + d3 / 2) / d3;
    prepare_axis(cx[0], cx[1], cx[2], cx[3], dt, dt2, dt3,
                 x_pos, x_vel, x_acc, x_jerk);
    prepare_axis(cy[0], cy[1], cy[2], cy[3], dt, dt2, dt3,
                 y_pos, y_vel, y_acc, y_jerk);
    for (int i = 1; i < n; i++) begin
      x_acc += x_jerk;
      x_vel += x_acc;
      x_pos += x_vel;
      y_acc += y_jerk;
      y_vel += y_acc;
      y_pos += y_vel;
      p.x    = trunc_to_point(x_pos);
      p.y    = trunc_to_point(y_pos);
      p.idx  = IDX_W'(i);
      p.last = (i == n - 1);
      expected_pts.push_back(p);
    end
  endfunction

  function automatic curve_t make_curve(int x0, int y0, int x1, int y1,
                                        int x2, int y2, int x3, int y3,
                                        int count);
    curve_t c;
    c.px[0] = COORD_W'(x0); c.py[0] = COORD_W'(y0);
    c.px[1] = COORD_W'(x1); c.py[1] = COORD_W'(y1);
    c.px[2] = COORD_W'(x2); c.py[2] = COORD_W'(y2);
    c.px[3] = COORD_W'(x3); c.py[3] = COORD_W'(y3);
    c.count = CNT_W'(count);
    return c;
  endfunction

  // Mostly full-range values, some extremes and some near zero
  function automatic logic signed [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return COORD_W'(-32768);
        1:       return COORD_W'(32767);
        2:       return COORD_W'(0);
        default: return COORD_W'(-1);
      endcase
    end else if (r <= 2) begin
      return COORD_W'($urandom_range(0, 200) - 100);
    end
    return COORD_W'($urandom);
  endfunction

  // Mostly short runs, some long ones, a few past the saturation point
  function automatic logic [CNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return CNT_W'($urandom_range(0, 1));
    if (r < 70) return CNT_W'($urandom_range(2, 12));
    if (r < 90) return CNT_W'($urandom_range(13, MAX_PTS));
    return CNT_W'($urandom_range(MAX_PTS + 1, 127));
  endfunction

  function automatic curve_t rand_curve();
    curve_t c;
    for (int k = 0; k < 4; k++) begin
      c.px[k] = rand_coord();
      c.py[k] = rand_coord();
    end
    c.count = rand_count();
    return c;
  endfunction

  // Offer one request, in bursts with random gaps between them
  task automatic send_curve(curve_t c);
    @(negedge clk);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    req_if.valid       <= 1'b1;
    req_if.p0_x        <= c.px[0];
    req_if.p0_y        <= c.py[0];
    req_if.p1_x        <= c.px[1];
    req_if.p1_y        <= c.py[1];
    req_if.p2_x        <= c.px[2];
    req_if.p2_y        <= c.py[2];
    req_if.p3_x        <= c.px[3];
    req_if.p3_y        <= c.py[3];
    req_if.point_count <= c.count;
    burst_left--;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_curve(c);
  endtask

  task automatic test_short_counts();
    send_curve(make_curve(-32768, 32767, 5, 6, 7, 8, 9, 10, 0));
    send_curve(make_curve(32767, -32768, -5, -6, -7, -8, -9, -10, 1));
    send_curve(make_curve(-32768, -32768, 100, -100, -100, 100, 32767, 32767, 2));
    send_curve(make_curve(32767, 0, 0, 32767, -32768, 0, 0, -32768, 3));
  endtask

  task automatic test_extreme_curves();
    send_curve(make_curve(-32768, -32768, 32767, 32767,
                          -32768, -32768, 32767, 32767, 64));
    send_curve(make_curve(32767, 32767, -32768, -32768,
                          32767, 32767, -32768, -32768, 64));
    send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0, 64));
    send_curve(make_curve(-1, -1, -1, -1, -1, -1, -1, -1, 64));
    send_curve(make_curve(32767, -32768, 10923, -10923,
                          -10923, 10923, -32768, 32767, 64));
    send_curve(make_curve(-32768, 32767, 32767, 32767,
                          32767, -32768, -32768, -32768, 5));
    send_curve(make_curve(1000, -1000, -20000, 30000,
                          20000, -30000, -1000, 1000, 10));
    send_curve(make_curve(32767, 32767, 32767, -32768,
                          -32768, 32767, -32768, -32768, 17));
    send_curve(make_curve(-3, 7, 11, -13, 17, -19, 23, -29, 33));
  endtask

  task automatic test_count_saturation();
    send_curve(make_curve(-32768, 32767, 32767, -32768,
                          -32768, 32767, 32767, -32768, 65));
    send_curve(make_curve(1234, -4321, -32768, 32767,
                          32767, -32768, -1234, 4321, 127));
    send_curve(make_curve(-7, -7, 7, 7, -7, 7, 7, -7, 100));
  endtask

  // Receiver holds off while requests keep coming, so the input backs up
  task automatic test_input_stall();
    hold_req   = 1'b1;
    burst_left = 10;
    for (int k = 0; k < 8; k++) begin
      curve_t c;
      c       = rand_curve();
      c.count = CNT_W'($urandom_range(2, 10));
      send_curve(c);
    end
  endtask

  task automatic test_random_curves();
    for (int k = 0; k < RAND_CURVES; k++) send_curve(rand_curve());
  endtask

  // Receiver ready, with changing stall patterns and an occasional long hold
  initial begin
    rdy_mode_e mode;
    int        left;
    int        phase;
    mode          = RDY_ALWAYS;
    left          = 0;
    phase         = 0;
    pt_if.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pt_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rdy_mode_e'($urandom_range(0, 3));
          left = $urandom_range(10, 150);
        end
        left--;
        phase++;
        case (mode)
          RDY_ALWAYS:      pt_if.ready <= 1'b1;
          RDY_COIN:        pt_if.ready <= 1'($urandom_range(0, 1));
          RDY_EVERY_THIRD: pt_if.ready <= (phase % 3 == 0);
          default:         pt_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each accepted point with the oldest expectation
  always @(posedge clk) begin
    point_t want;
    if (rst_n && pt_if.valid && pt_if.ready) begin
      if (expected_pts.size() == 0) begin
        $error("unexpected point: x %0d y %0d index %0d last %0b",
               $signed(pt_if.out_x), $signed(pt_if.out_y),
               pt_if.point_index, pt_if.last_point);
        err_cnt++;
      end else begin
        want = expected_pts.pop_front();
        if (pt_if.out_x !== want.x) begin
          $error("out_x: expected %0d, got %0d", $signed(want.x), $signed(pt_if.out_x));
          err_cnt++;
        end
        if (pt_if.out_y !== want.y) begin
          $error("out_y: expected %0d, got %0d", $signed(want.y), $signed(pt_if.out_y));
          err_cnt++;
        end
        if (pt_if.point_index !== want.idx) begin
          $error("point_index: expected %0d, got %0d", want.idx, pt_if.point_index);
          err_cnt++;
        end
        if (pt_if.last_point !== want.last) begin
          $error("last_point: expected %0b, got %0b", want.last, pt_if.last_point);
          err_cnt++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int waited;
    err_cnt            = 0;
    burst_left         = 0;
    hold_req           = 1'b0;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.p0_x        = '0;
    req_if.p0_y        = '0;
    req_if.p1_x        = '0;
    req_if.p1_y        = '0;
    req_if.p2_x        = '0;
    req_if.p2_y        = '0;
    req_if.p3_x        = '0;
    req_if.p3_y        = '0;
    req_if.point_count = '0;
    x_pos = '0; x_vel = '0; x_acc = '0; x_jerk = '0;
    y_pos = '0; y_vel = '0; y_acc = '0; y_jerk = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_short_counts();
    test_extreme_curves();
    test_count_saturation();
    test_input_stall();
    test_random_curves();

    @(negedge clk);
    req_if.valid <= 1'b0;

    // drain, then watch for stray points
    waited = 0;
    while (expected_pts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_pts.size() != 0) begin
      $error("%0d expected points never arrived", expected_pts.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* cubic_bezier_forward_diff_core.f */
hw/rtl/bcf_pkg.sv
hw/rtl/bcf_if.sv
hw/rtl/bcf_front.sv
hw/rtl/bcf_queue.sv
hw/rtl/bcf_back.sv
hw/rtl/cubic_bezier_forward_diff_core.sv
tb/tb_top.sv
